FILE: hw/rtl/sati_pkg.sv
package sati_pkg;

    // table geometry
    localparam int TABLE_DEPTH_DEFAULT = 16;
    localparam int ADDR_W              = 48;

    // result fields
    localparam int STATUS_W    = 2;
    localparam int FIELD_W     = 5;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 16;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

endpackage

FILE: hw/rtl/sati_store.sv
module sati_store #(
    parameter int DEPTH = sati_pkg::TABLE_DEPTH_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [sati_pkg::ADDR_W-1:0] o_rd_data,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [sati_pkg::ADDR_W-1:0] i_wr_data
);

    logic [sati_pkg::ADDR_W-1:0] r_mem [DEPTH];
    logic [sati_pkg::ADDR_W-1:0] r_rd_data;

    // one write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // one read port, registered data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/sorted_address_table_insert.sv
// Sorted address table: keeps up to TABLE_DEPTH 48-bit addresses in ascending
// order in a single-port-read, single-port-write memory and answers every
// request with one result (status, slot, new entry count). One request is
// worked at a time. The memory read port sets the pace: the search reads one
// entry per cycle from slot 0 until it meets an entry not below the address,
// and an insert below the top then moves the entries above the insertion
// point up one slot per cycle. Each request goes through the search (S_SCAN),
// then, for an insert below the top, the move and write (S_SHIFT), then the
// load of the result into the output register (S_RESULT); an append at the
// top, a duplicate and a drop on a full table go from the search straight to
// S_RESULT. S_RESULT waits while the output register still holds the
// previous result. A finished result waits in the output register while the
// next request is accepted and searched.
module sorted_address_table_insert #(
    parameter int TABLE_DEPTH = sati_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request: [47:0] address
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [sati_pkg::IN_TDATA_W-1:0] i_s_tdata,
    // result: [1:0] status, [6:2] slot, [11:7] entry_count, [15:12] zero
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [sati_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_RESULT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0]               r_count, n_count;
    logic [sati_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic [CW-1:0]               r_issue, n_issue;
    logic [AW-1:0]               r_cmp, n_cmp;
    logic                        r_pend, n_pend;
    logic [CW-1:0]               r_pos, n_pos;
    logic [CW-1:0]               r_src, n_src;
    logic [AW-1:0]               r_wdst, n_wdst;
    logic                        r_wpend, n_wpend;
    sati_pkg::t_status           r_res_status, n_res_status;
    logic [CW-1:0]               r_res_slot, n_res_slot;
    logic                        r_m_tvalid, n_m_tvalid;
    logic [sati_pkg::OUT_TDATA_W-1:0] r_m_tdata, n_m_tdata;

    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [sati_pkg::ADDR_W-1:0] rd_data;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [sati_pkg::ADDR_W-1:0] wr_data;

    logic          s_accept;
    logic          hit;
    logic          equal;
    logic [CW-1:0] pos_found;
    logic [CW-1:0] src_m1;

    assign s_accept  = i_s_tvalid && (r_state == S_IDLE);
    assign hit       = r_pend && (rd_data >= r_addr);
    assign equal     = r_pend && (rd_data == r_addr);
    assign pos_found = hit ? CW'(r_cmp) : r_count;
    assign src_m1    = r_src - 1'b1;

    // address memory
    sati_store #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // sequencer: search, move up, place, report
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_addr       = r_addr;
        n_issue      = r_issue;
        n_cmp        = r_cmp;
        n_pend       = r_pend;
        n_pos        = r_pos;
        n_src        = r_src;
        n_wdst       = r_wdst;
        n_wpend      = r_wpend;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_m_tvalid   = r_m_tvalid;
        n_m_tdata    = r_m_tdata;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = r_pos[AW-1:0];
        wr_data      = r_addr;

        // output register drains independently
        if (r_m_tvalid && i_m_tready) begin
            n_m_tvalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    // read slot 0 right away
                    n_addr  = i_s_tdata[sati_pkg::ADDR_W-1:0];
                    rd_en   = 1'b1;
                    rd_addr = '0;
                    n_cmp   = '0;
                    n_pend  = (r_count != '0);
                    n_issue = CW'(1);
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // keep one read in flight ahead of the compare
                if (r_issue < r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = r_issue[AW-1:0];
                    n_cmp   = r_issue[AW-1:0];
                    n_issue = r_issue + 1'b1;
                    n_pend  = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (hit || !r_pend) begin
                    if (equal) begin
                        n_res_status = sati_pkg::ST_PRESENT;
                        n_res_slot   = CW'(r_cmp);
                        n_state      = S_RESULT;
                    end else if (r_count == DEPTH_C) begin
                        n_res_status = sati_pkg::ST_FULL;
                        n_res_slot   = '0;
                        n_state      = S_RESULT;
                    end else if (pos_found == r_count) begin
                        // append at the top, nothing to move
                        wr_en        = 1'b1;
                        wr_addr      = pos_found[AW-1:0];
                        n_count      = r_count + 1'b1;
                        n_res_status = sati_pkg::ST_INSERTED;
                        n_res_slot   = pos_found;
                        n_state      = S_RESULT;
                    end else begin
                        n_pos   = pos_found;
                        n_src   = r_count;
                        n_wpend = 1'b0;
                        n_state = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                // read slot k-1, write it to slot k next cycle, top down
                if (r_src > r_pos) begin
                    rd_en   = 1'b1;
                    rd_addr = src_m1[AW-1:0];
                    n_wdst  = r_src[AW-1:0];
                    n_src   = src_m1;
                    n_wpend = 1'b1;
                end else begin
                    n_wpend = 1'b0;
                end
                if (r_wpend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_wdst;
                    wr_data = rd_data;
                end else if (r_src == r_pos) begin
                    // gap open: place the new address
                    wr_en        = 1'b1;
                    wr_addr      = r_pos[AW-1:0];
                    n_count      = r_count + 1'b1;
                    n_res_status = sati_pkg::ST_INSERTED;
                    n_res_slot   = r_pos;
                    n_state      = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!r_m_tvalid || i_m_tready) begin
                    n_m_tvalid = 1'b1;
                    n_m_tdata  = {
                        {(sati_pkg::OUT_TDATA_W - sati_pkg::STATUS_W
                          - 2 * sati_pkg::FIELD_W){1'b0}},
                        sati_pkg::FIELD_W'(r_count),
                        sati_pkg::FIELD_W'(r_res_slot),
                        r_res_status
                    };
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_pend     <= 1'b0;
            r_wpend    <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_pend     <= n_pend;
            r_wpend    <= n_wpend;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_issue      <= n_issue;
        r_cmp        <= n_cmp;
        r_pos        <= n_pos;
        r_src        <= n_src;
        r_wdst       <= n_wdst;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_m_tdata    <= n_m_tdata;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

endmodule

FILE: hw/rtl/sati_checker.sv
module sati_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [sati_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    // no result right after reset
    a_reset_quiet: assert property (
        @(posedge i_clk) !i_rst_n |=> !o_m_tvalid
    ) else $error("result valid after reset");

    // one request at a time: taking a request closes the input
    a_one_at_a_time: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready
    ) else $error("second request taken while one is in work");

    // a dropped address reports slot zero
    a_full_slot: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[1:0] == sati_pkg::ST_FULL) |-> (o_m_tdata[6:2] == '0)
    ) else $error("full result with nonzero slot");

    // a stalled result holds
    a_result_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
    ) else $error("stalled result changed");

endmodule

bind sorted_address_table_insert sati_checker u_sati_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
